FILE: src/i2cm_pkg.sv
// Shared types and constants for the I2C master transaction engine.
// No dependencies.
package i2cm_pkg;

   localparam int BUFFER_DEPTH = 256;
   localparam int BUF_AW       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_AW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_BEGIN = 2'd1;
   localparam logic [1:0] ACT_LOAD  = 2'd2;

   localparam logic [1:0] MODE_WRITE     = 2'd0;
   localparam logic [1:0] MODE_READ      = 2'd1;
   localparam logic [1:0] MODE_REG_WRITE = 2'd2;
   localparam logic [1:0] MODE_REG_READ  = 2'd3;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_ADDR_NACK  = 3'd1;
   localparam logic [2:0] ST_REG_NACK   = 3'd2;
   localparam logic [2:0] ST_DATA_NACK  = 3'd3;
   localparam logic [2:0] ST_ADDR2_NACK = 3'd4;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_BEGIN,
      CMD_LOAD,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [1:0]   mode;
      logic [7:0]   device_address;
      logic [7:0]   register_address;
      logic [7:0]   length;
      logic [7:0]   write_byte;
      logic         sda_in;
   } cmd_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic [7:0] read_data;
      logic       read_valid;
      logic       busy_res;
      logic       finished;
      logic [2:0] status;
   } rsp_type;

endpackage

FILE: src/i2cm_if.sv
// Valid/ready channel interfaces for request and response beats.
// No dependencies.
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [1:0] mode;
   logic [7:0] device_address;
   logic [7:0] register_address;
   logic [7:0] length;
   logic [7:0] write_byte;
   logic       sda_in;

   modport source (output valid, action, mode, device_address, register_address, length,
                   write_byte, sda_in, input ready);
   modport sink (input valid, action, mode, device_address, register_address, length,
                 write_byte, sda_in, output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic [7:0] read_data;
   logic       read_valid;
   logic       busy_res;
   logic       finished;
   logic [2:0] status;

   modport source (output valid, scl_level, sda_level, read_data, read_valid, busy_res,
                   finished, status, input ready);
   modport sink (input valid, scl_level, sda_level, read_data, read_valid, busy_res,
                 finished, status, output ready);
endinterface

FILE: src/i2cm_front.sv
// Front end: accepts request beats and decodes them into queue commands.
// Depends on i2cm_pkg and i2cm_req_if.
module i2cm_front import i2cm_pkg::*; (
   i2cm_req_if.sink req_if,
   input  logic     queue_full,
   output logic     push,
   output cmd_type  push_cmd
);

   assign req_if.ready = !queue_full;
   assign push         = req_if.valid && !queue_full;

   always_comb begin
      push_cmd.mode             = req_if.mode;
      push_cmd.device_address   = req_if.device_address;
      push_cmd.register_address = req_if.register_address;
      push_cmd.length           = req_if.length;
      push_cmd.write_byte       = req_if.write_byte;
      push_cmd.sda_in           = req_if.sda_in;
      unique case (req_if.action)
         ACT_TICK:  push_cmd.kind = CMD_TICK;
         ACT_BEGIN: push_cmd.kind = CMD_BEGIN;
         ACT_LOAD:  push_cmd.kind = CMD_LOAD;
         default:   push_cmd.kind = CMD_NOP;
      endcase
   end

endmodule

FILE: src/i2cm_queue.sv
// Short command queue between front end and engine.
// Depends on i2cm_pkg.
module i2cm_queue import i2cm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int CW = QUEUE_AW + 1;

   cmd_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         count_ff, count_in;

   assign full       = (count_ff == CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("queue push while full");
   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("queue pop while empty");
   assert property (@(posedge clock) disable iff (reset)
                    (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");

endmodule

FILE: src/i2cm_engine.sv
// Back end: pin sequencer, write buffer and response register.
// Depends on i2cm_pkg and i2cm_rsp_if.
module i2cm_engine import i2cm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     head_valid,
   input  cmd_type  head_cmd,
   output logic     pop,
   i2cm_rsp_if.source rsp_if
);

   localparam int AW1 = BUF_AW + 1;

   typedef enum logic [3:0] {
      PH_IDLE, PH_START1, PH_START2, PH_TX_ADDR, PH_ACK_ADDR, PH_TX_REG, PH_ACK_REG,
      PH_TX_DATA, PH_ACK_DATA, PH_TX_ADDR2, PH_ACK_ADDR2, PH_RX_REL, PH_RX_BIT,
      PH_ACK_OUT, PH_STOP
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [1:0]        step_ff, step_in;
   logic [2:0]        bit_ff, bit_in;
   logic [7:0]        byte_cnt_ff, byte_cnt_in;
   logic [7:0]        shift_ff, shift_in;
   logic              scl_line_ff, scl_line_in;
   logic              sda_line_ff, sda_line_in;
   logic [1:0]        mode_ff, mode_in;
   logic [7:0]        addr_ff, addr_in;
   logic [7:0]        reg_addr_ff, reg_addr_in;
   logic [7:0]        length_ff, length_in;
   logic [BUF_AW-1:0] load_idx_ff, load_idx_in;
   logic [BUF_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0]        status_ff, status_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic [7:0]        buf_mem [BUFFER_DEPTH];
   logic [7:0]        buf_rd_ff;
   logic [BUF_AW-1:0] rd_next;
   logic [BUF_AW-1:0] buf_rd_addr;
   logic              buf_we;
   logic              take;
   logic              rx_valid;
   logic [7:0]        rx_data;
   logic              fin;
   logic [7:0]        byte_cnt_inc;
   logic              nack;

   function automatic logic [BUF_AW-1:0] idx_inc(input logic [BUF_AW-1:0] idx);
      return (idx == BUF_AW'(BUFFER_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   assign take         = head_valid && (!out_valid_ff || rsp_if.ready);
   assign pop          = take;
   assign rd_next      = idx_inc(rd_ptr_ff);
   assign buf_rd_addr  = (phase_ff == PH_ACK_DATA) ? rd_next : rd_ptr_ff;
   assign byte_cnt_inc = byte_cnt_ff + 8'd1;
   assign nack         = shift_ff[0];

   always_comb begin
      phase_in    = phase_ff;
      step_in     = step_ff;
      bit_in      = bit_ff;
      byte_cnt_in = byte_cnt_ff;
      shift_in    = shift_ff;
      scl_line_in = scl_line_ff;
      sda_line_in = sda_line_ff;
      mode_in     = mode_ff;
      addr_in     = addr_ff;
      reg_addr_in = reg_addr_ff;
      length_in   = length_ff;
      load_idx_in = load_idx_ff;
      rd_ptr_in   = rd_ptr_ff;
      status_in   = status_ff;
      buf_we      = 1'b0;
      rx_valid    = 1'b0;
      rx_data     = 8'd0;
      fin         = 1'b0;

      if (take) begin
         unique case (head_cmd.kind)
            CMD_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  step_in = step_ff + 2'd1;
                  unique case (phase_ff)
                     PH_START1, PH_START2: begin
                        unique case (step_ff)
                           2'd0: sda_line_in = 1'b1;
                           2'd1: scl_line_in = 1'b1;
                           2'd2: sda_line_in = 1'b0;
                           default: begin
                              scl_line_in = 1'b0;
                              step_in     = 2'd0;
                              bit_in      = 3'd0;
                              if (phase_ff == PH_START1) begin
                                 phase_in = PH_TX_ADDR;
                                 shift_in = (mode_ff == MODE_READ) ? (addr_ff | 8'd1) : addr_ff;
                              end else begin
                                 phase_in = PH_TX_ADDR2;
                                 shift_in = addr_ff | 8'd1;
                              end
                           end
                        endcase
                     end
                     PH_TX_ADDR, PH_TX_REG, PH_TX_DATA, PH_TX_ADDR2: begin
                        unique case (step_ff)
                           2'd0: sda_line_in = shift_ff[7];
                           2'd1: scl_line_in = 1'b1;
                           default: begin
                              scl_line_in = 1'b0;
                              shift_in    = {shift_ff[6:0], 1'b0};
                              step_in     = 2'd0;
                              if (bit_ff == 3'd7) begin
                                 bit_in = 3'd0;
                                 unique case (phase_ff)
                                    PH_TX_ADDR: phase_in = PH_ACK_ADDR;
                                    PH_TX_REG:  phase_in = PH_ACK_REG;
                                    PH_TX_DATA: phase_in = PH_ACK_DATA;
                                    default:    phase_in = PH_ACK_ADDR2;
                                 endcase
                              end else begin
                                 bit_in = bit_ff + 3'd1;
                              end
                           end
                        endcase
                     end
                     PH_ACK_ADDR, PH_ACK_REG, PH_ACK_DATA, PH_ACK_ADDR2: begin
                        unique case (step_ff)
                           2'd0: sda_line_in = 1'b1;
                           2'd1: begin
                              scl_line_in = 1'b1;
                              shift_in    = {7'd0, head_cmd.sda_in};
                           end
                           default: begin
                              scl_line_in = 1'b0;
                              step_in     = 2'd0;
                              bit_in      = 3'd0;
                              unique case (phase_ff)
                                 PH_ACK_ADDR: begin
                                    priority if (nack) begin
                                       status_in = ST_ADDR_NACK;
                                       phase_in  = PH_STOP;
                                    end else if (mode_ff == MODE_WRITE) begin
                                       if (byte_cnt_ff == length_ff) begin
                                          status_in = ST_OK;
                                          phase_in  = PH_STOP;
                                       end else begin
                                          phase_in = PH_TX_DATA;
                                          shift_in = buf_rd_ff;
                                       end
                                    end else if (mode_ff == MODE_READ) begin
                                       if (byte_cnt_ff == length_ff) begin
                                          status_in = ST_OK;
                                          phase_in  = PH_STOP;
                                       end else begin
                                          phase_in = PH_RX_REL;
                                       end
                                    end else begin
                                       phase_in = PH_TX_REG;
                                       shift_in = reg_addr_ff;
                                    end
                                 end
                                 PH_ACK_REG: begin
                                    priority if (nack) begin
                                       status_in = ST_REG_NACK;
                                       phase_in  = PH_STOP;
                                    end else if (mode_ff == MODE_REG_READ) begin
                                       phase_in = PH_START2;
                                    end else if (byte_cnt_ff == length_ff) begin
                                       status_in = ST_OK;
                                       phase_in  = PH_STOP;
                                    end else begin
                                       phase_in = PH_TX_DATA;
                                       shift_in = buf_rd_ff;
                                    end
                                 end
                                 PH_ACK_DATA: begin
                                    if (nack) begin
                                       status_in = ST_DATA_NACK;
                                       phase_in  = PH_STOP;
                                    end else begin
                                       byte_cnt_in = byte_cnt_inc;
                                       rd_ptr_in   = rd_next;
                                       if (byte_cnt_inc == length_ff) begin
                                          status_in = ST_OK;
                                          phase_in  = PH_STOP;
                                       end else begin
                                          phase_in = PH_TX_DATA;
                                          shift_in = buf_rd_ff;
                                       end
                                    end
                                 end
                                 default: begin
                                    priority if (nack) begin
                                       status_in = ST_ADDR2_NACK;
                                       phase_in  = PH_STOP;
                                    end else if (byte_cnt_ff == length_ff) begin
                                       status_in = ST_OK;
                                       phase_in  = PH_STOP;
                                    end else begin
                                       phase_in = PH_RX_REL;
                                    end
                                 end
                              endcase
                           end
                        endcase
                     end
                     PH_RX_REL: begin
                        sda_line_in = 1'b1;
                        phase_in    = PH_RX_BIT;
                        step_in     = 2'd0;
                        bit_in      = 3'd0;
                     end
                     PH_RX_BIT: begin
                        if (step_ff == 2'd0) begin
                           scl_line_in = 1'b1;
                           shift_in    = {shift_ff[6:0], head_cmd.sda_in};
                        end else begin
                           scl_line_in = 1'b0;
                           step_in     = 2'd0;
                           if (bit_ff == 3'd7) begin
                              rx_valid = 1'b1;
                              rx_data  = shift_ff;
                              phase_in = PH_ACK_OUT;
                              bit_in   = 3'd0;
                           end else begin
                              bit_in = bit_ff + 3'd1;
                           end
                        end
                     end
                     PH_ACK_OUT: begin
                        unique case (step_ff)
                           2'd0: sda_line_in = ({1'b0, byte_cnt_ff} + 9'd1 == {1'b0, length_ff});
                           2'd1: scl_line_in = 1'b1;
                           default: begin
                              scl_line_in = 1'b0;
                              step_in     = 2'd0;
                              bit_in      = 3'd0;
                              byte_cnt_in = byte_cnt_inc;
                              rd_ptr_in   = rd_next;
                              if (byte_cnt_inc == length_ff) begin
                                 status_in = ST_OK;
                                 phase_in  = PH_STOP;
                              end else begin
                                 phase_in = PH_RX_REL;
                              end
                           end
                        endcase
                     end
                     PH_STOP: begin
                        unique case (step_ff)
                           2'd0: sda_line_in = 1'b0;
                           2'd1: scl_line_in = 1'b1;
                           default: begin
                              sda_line_in = 1'b1;
                              fin         = 1'b1;
                              phase_in    = PH_IDLE;
                              step_in     = 2'd0;
                              bit_in      = 3'd0;
                           end
                        endcase
                     end
                     default: begin
                        phase_in = PH_IDLE;
                        step_in  = 2'd0;
                        bit_in   = 3'd0;
                     end
                  endcase
               end
            end
            CMD_BEGIN: begin
               if (phase_ff == PH_IDLE) begin
                  mode_in     = head_cmd.mode;
                  addr_in     = head_cmd.device_address;
                  reg_addr_in = head_cmd.register_address;
                  length_in   = head_cmd.length;
                  byte_cnt_in = 8'd0;
                  rd_ptr_in   = '0;
                  status_in   = ST_OK;
                  load_idx_in = '0;
                  phase_in    = PH_START1;
                  step_in     = 2'd0;
                  bit_in      = 3'd0;
               end
            end
            CMD_LOAD: begin
               if (phase_ff == PH_IDLE) begin
                  buf_we      = 1'b1;
                  load_idx_in = idx_inc(load_idx_ff);
               end
            end
            default: begin
            end
         endcase
      end

      out_in.scl_level  = scl_line_in;
      out_in.sda_level  = sda_line_in;
      out_in.read_data  = rx_data;
      out_in.read_valid = rx_valid;
      out_in.busy_res   = (phase_in != PH_IDLE);
      out_in.finished   = fin;
      out_in.status     = status_in;

      out_valid_in = take || (out_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[load_idx_ff] <= head_cmd.write_byte;
      end
      buf_rd_ff <= buf_mem[buf_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         step_ff      <= 2'd0;
         bit_ff       <= 3'd0;
         byte_cnt_ff  <= 8'd0;
         shift_ff     <= 8'd0;
         scl_line_ff  <= 1'b1;
         sda_line_ff  <= 1'b1;
         mode_ff      <= 2'd0;
         addr_ff      <= 8'd0;
         reg_addr_ff  <= 8'd0;
         length_ff    <= 8'd0;
         load_idx_ff  <= '0;
         rd_ptr_ff    <= '0;
         status_ff    <= ST_OK;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         bit_ff       <= bit_in;
         byte_cnt_ff  <= byte_cnt_in;
         shift_ff     <= shift_in;
         scl_line_ff  <= scl_line_in;
         sda_line_ff  <= sda_line_in;
         mode_ff      <= mode_in;
         addr_ff      <= addr_in;
         reg_addr_ff  <= reg_addr_in;
         length_ff    <= length_in;
         load_idx_ff  <= load_idx_in;
         rd_ptr_ff    <= rd_ptr_in;
         status_ff    <= status_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.scl_level  = out_ff.scl_level;
   assign rsp_if.sda_level  = out_ff.sda_level;
   assign rsp_if.read_data  = out_ff.read_data;
   assign rsp_if.read_valid = out_ff.read_valid;
   assign rsp_if.busy_res   = out_ff.busy_res;
   assign rsp_if.finished   = out_ff.finished;
   assign rsp_if.status     = out_ff.status;

   assert property (@(posedge clock) disable iff (reset)
                    (out_valid_ff && out_ff.finished) |-> !out_ff.busy_res)
      else $error("finishing beat still reports busy");
   assert property (@(posedge clock) disable iff (reset)
                    (out_valid_ff && out_ff.read_valid) |-> !out_ff.scl_level)
      else $error("received byte reported with SCL high");
   assert property (@(posedge clock) disable iff (reset)
                    (phase_ff == PH_IDLE) |-> (step_ff == 2'd0 && bit_ff == 3'd0))
      else $error("bit counters not cleared in idle");
   assert property (@(posedge clock) disable iff (reset)
                    {1'b0, load_idx_ff} < AW1'(BUFFER_DEPTH) &&
                    {1'b0, rd_ptr_ff} < AW1'(BUFFER_DEPTH))
      else $error("buffer index out of range");

endmodule

FILE: src/i2c_master_transaction_engine.sv
// Top level of the I2C master transaction engine: front end, command queue, engine.
// Depends on i2cm_pkg, i2cm_if, i2cm_front, i2cm_queue and i2cm_engine.
//
//   channel   dir   beat
//   req_if    in    action, mode, device_address, register_address, length,
//                   write_byte, sda_in
//   rsp_if    out   scl_level, sda_level, read_data, read_valid, busy_res,
//                   finished, status
//
// One request beat per cycle while req_if.ready is high, one response beat per request beat.
// A request is registered in the command queue, and its response in the output register.
// The write buffer has no reset and no clearing pass; it is filled by load beats.
// A stalled response holds in the output register; the two-entry queue absorbs
// the request beats taken meanwhile and then drops req_if.ready.
module i2c_master_transaction_engine import i2cm_pkg::*; (
   input logic        clock,
   input logic        reset,
   i2cm_req_if.sink   req_if,
   i2cm_rsp_if.source rsp_if
);

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   i2cm_front u_front (
      .req_if     (req_if),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   i2cm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   i2cm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule
